// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants, status codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 31;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 5;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  typedef logic [VAL_W-1:0] val_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic ins;
    logic pop;
    val_t value;
  } cell_ctl_t;

  // Where a cell stands relative to the current fill level.
  typedef struct packed {
    logic occ;
    logic at_count;
  } cell_pos_t;

endpackage

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain. It compares the incoming value with its own
// and takes the new value, its left or right neighbor's value, or keeps its own.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::cell_pos_t pos,
  input  spq_pkg::val_t     left_val,
  input  logic              left_gt,
  input  spq_pkg::val_t     right_val,
  output spq_pkg::val_t     val,
  output logic              gt
);

  spq_pkg::val_t val_next;

  assign gt = pos.occ && (val > ctl.value);

  always_comb begin
    val_next = val;
    if (ctl.pop) begin
      val_next = right_val;
    end else if (ctl.ins) begin
      if (left_gt) begin
        val_next = left_val;
      end else if (gt || pos.at_count) begin
        val_next = ctl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== design/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Min-priority queue held as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The input channel carries an opcode and a value. An insert places the
// value in ascending order after any equal stored values. A pop removes and
// returns the smallest value. Every accepted transfer yields exactly one
// result transfer with a status, the popped value and the occupancy.
// All cells compare the new value against their own in parallel and shift
// together. The result appears in the output register on the cycle after
// acceptance, and one item can be accepted every cycle while the receiver
// keeps up.
// When the receiver stalls, the result holds in the output register and
// the input is stalled until that result is taken.
// An insert into a full queue is dropped and reported as full. A pop on an
// empty queue reports empty with a zero value.
// Reset empties the queue at once and clears the output valid. The stored
// values are not cleared, since slots above the fill level are never read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [spq_pkg::VAL_W-1:0]      item_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spq_pkg::STAT_W-1:0]     status,
  output logic [spq_pkg::VAL_W-1:0]      popped_value,
  output logic [spq_pkg::OCC_W-1:0]      occupancy
);

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;
  logic                      accept;
  logic                      full;
  logic                      empty;
  spq_pkg::cell_ctl_t        ctl;
  spq_pkg::val_t             cell_val [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0] cell_gt;
  logic [spq_pkg::STAT_W-1:0] status_next;
  spq_pkg::val_t             popped_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == spq_pkg::CNT_FULL);
  assign empty    = (count == '0);

  assign ctl.ins   = accept && (opcode == spq_pkg::OP_INSERT) && !full;
  assign ctl.pop   = accept && (opcode == spq_pkg::OP_POP) && !empty;
  assign ctl.value = item_value;

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::cell_pos_t pos;
    spq_pkg::val_t      left_val;
    spq_pkg::val_t      right_val;
    logic               left_gt;

    assign pos.occ      = (spq_pkg::CNT_W'(i) < count);
    assign pos.at_count = (spq_pkg::CNT_W'(i) == count);

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (pos),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = spq_pkg::ST_OK;
    popped_next = '0;
    if (opcode == spq_pkg::OP_INSERT) begin
      if (full) begin
        status_next = spq_pkg::ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = spq_pkg::ST_EMPTY;
      end else begin
        count_next  = count - 1'b1;
        popped_next = cell_val[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      popped_value <= popped_next;
      occupancy    <= spq_pkg::OCC_W'(count_next);
    end
  end

endmodule

// ===== design/spq_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on the result channel of the sorted priority queue.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [spq_pkg::STAT_W-1:0] status,
  input logic [spq_pkg::VAL_W-1:0]  popped_value,
  input logic [spq_pkg::OCC_W-1:0]  occupancy
);

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::ST_EMPTY) |-> popped_value == '0)
    else $error("Pop on an empty queue returned a nonzero value.");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::ST_EMPTY) |-> occupancy == '0)
    else $error("Empty status reported with a nonzero occupancy.");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::ST_FULL) |-> occupancy == spq_pkg::OCC_FULL)
    else $error("Full status reported while the queue was not full.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(popped_value)
      && $stable(occupancy))
    else $error("Stalled result transfer changed.");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .popped_value (popped_value),
  .occupancy    (occupancy)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Drives insert and pop transfers into the queue under a range of idle and
// stall patterns and checks every result against a predicted sorted queue.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 388;

  typedef logic [spq_pkg::STAT_W-1:0] stat_t;
  typedef logic [spq_pkg::OCC_W-1:0]  occ_t;

  // Keeps the queue contents expected after every accepted transfer and
  // the results that are still to come out of the block.
  class spq_scoreboard;
    typedef struct {
      stat_t         status;
      spq_pkg::val_t popped;
      occ_t          occ;
    } queue_result_t;

    spq_pkg::val_t sorted_vals[$];
    queue_result_t expected_results[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void predict_request(input logic op, input spq_pkg::val_t v);
      queue_result_t r;
      int            pos;
      r.status = spq_pkg::ST_OK;
      r.popped = '0;
      if (op == spq_pkg::OP_INSERT) begin
        if (sorted_vals.size() >= spq_pkg::DEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < sorted_vals.size() && sorted_vals[pos] <= v) pos++;
          sorted_vals.insert(pos, v);
        end
      end else begin
        if (sorted_vals.size() == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.popped = sorted_vals.pop_front();
        end
      end
      r.occ = occ_t'(sorted_vals.size());
      expected_results.push_back(r);
    endfunction

    task check_result(input stat_t st, input spq_pkg::val_t pv, input occ_t occ);
      queue_result_t e;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result st=%0d val=%0h occ=%0d", st, pv, occ));
      end else begin
        e = expected_results.pop_front();
        if (st !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
        if (pv !== e.popped)
          report_mismatch($sformatf("popped_value %0h, expected %0h", pv, e.popped));
        if (occ !== e.occ)
          report_mismatch($sformatf("occupancy %0d, expected %0d", occ, e.occ));
      end
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          opcode = spq_pkg::OP_INSERT;
  spq_pkg::val_t item_value = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  stat_t         status;
  spq_pkg::val_t popped_value;
  occ_t          occupancy;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  spq_scoreboard sb = new();

  sorted_priority_queue_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .popped_value (popped_value),
    .occupancy    (occupancy)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Transfers on both channels are noted in one place so that an input and
  // a result in the same cycle are always seen in that order.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.predict_request(opcode, item_value);
      if (out_valid && !out_stall) sb.check_result(status, popped_value, occupancy);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic op, input spq_pkg::val_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      item_value <= spq_pkg::val_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    item_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic spq_pkg::val_t pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return spq_pkg::val_t'($urandom_range(8, 1));
      4, 5, 6:    return spq_pkg::val_t'($urandom);
      7:          return '0;
      8:          return '1;
      default:    return spq_pkg::val_t'(1) << $urandom_range(spq_pkg::VAL_W - 1);
    endcase
  endfunction

  // Runs of insert-heavy, pop-heavy and balanced traffic so that the queue
  // swings between empty and full many times.
  task automatic run_random(input int n);
    int sent;
    int seg_len;
    int ins_pct;
    sent = 0;
    while (sent < n) begin
      seg_len = $urandom_range(50, 10);
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      for (int i = 0; i < seg_len && sent < n; i++) begin
        send_item(($urandom_range(99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_POP,
                  pick_value());
        sent++;
      end
    end
  endtask

  task automatic run_directed();
    spq_pkg::val_t fill_vals[16];
    fill_vals = '{31'h7FFFFFFF, 31'h0, 31'd5, 31'd5, 31'd5, 31'd1, 31'h40000000,
                  31'h2AAAAAAA, 31'h55555555, 31'd7, 31'd6, 31'd5, 31'd100, 31'd2,
                  31'd3, 31'h7FFFFFFE};
    send_item(spq_pkg::OP_POP, 31'h7FFFFFFF);
    foreach (fill_vals[i]) send_item(spq_pkg::OP_INSERT, fill_vals[i]);
    send_item(spq_pkg::OP_INSERT, 31'd9);
    send_item(spq_pkg::OP_POP, '0);
    send_item(spq_pkg::OP_POP, '0);
    send_item(spq_pkg::OP_POP, '0);
    send_item(spq_pkg::OP_INSERT, 31'd4);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random(PHASE_ITEMS);

    send_idle_pct = 67;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_stall_pct = 67;
    run_random(PHASE_ITEMS);

    send_idle_pct = 32;
    recv_stall_pct = 32;
    run_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
